>>> hdl/svat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svat_pkg: shared types and helpers for the sparse vector accumulate table
// Field widths, operation and status codes, item structs, controller
// state and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package svat_pkg;

	localparam int ID_BITS      = 48;
	localparam int COEFF_BITS   = 32;
	localparam int IDX_BITS     = 6;
	localparam int SLOT_BITS    = 6;
	localparam int STATUS_BITS  = 3;
	localparam int COUNT_BITS   = 7;
	localparam int DEF_CAPACITY = 64;

	typedef enum logic [1:0] {
		OP_ACCUM  = 2'd0,
		OP_INSERT = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		RS_MATCHED  = 3'd0,
		RS_APPENDED = 3'd1,
		RS_FULL     = 3'd2,
		RS_READ_OK  = 3'd3,
		RS_READ_OOR = 3'd4
	} status_t;

	typedef struct packed {
		op_t                           opcode;
		logic [ID_BITS-1:0]            state_id;
		logic signed [COEFF_BITS-1:0]  coeff_re;
		logic signed [COEFF_BITS-1:0]  coeff_im;
		logic [IDX_BITS-1:0]           read_index;
	} in_item_t;

	typedef struct packed {
		status_t                       status;
		logic [SLOT_BITS-1:0]          slot;
		logic [ID_BITS-1:0]            entry_id;
		logic signed [COEFF_BITS-1:0]  entry_re;
		logic signed [COEFF_BITS-1:0]  entry_im;
		logic                          saturated;
		logic [COUNT_BITS-1:0]         entry_count;
	} out_item_t;

	// One stored entry as it sits in the table memory.
	typedef struct packed {
		logic [ID_BITS-1:0]            id;
		logic signed [COEFF_BITS-1:0]  re;
		logic signed [COEFF_BITS-1:0]  im;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_SCAN   = 2'd1,
		S_FINISH = 2'd2
	} state_t;

	typedef struct packed {
		logic load;
		logic advance;
		logic mark_hit;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_end;
		logic id_hit;
	} ctrl_stat_t;

	typedef struct packed {
		logic                          clip;
		logic signed [COEFF_BITS-1:0]  val;
	} sat_res_t;

	// Saturating add of two signed values; clamps to the most positive or
	// most negative representable value and flags the clip.
	function automatic sat_res_t sat_add(input logic signed [COEFF_BITS-1:0] a,
			input logic signed [COEFF_BITS-1:0] b);
		logic signed [COEFF_BITS:0] s;
		sat_res_t r;
		s = {a[COEFF_BITS-1], a} + {b[COEFF_BITS-1], b};
		if (s[COEFF_BITS] != s[COEFF_BITS-1]) begin
			r.clip = 1'b1;
			r.val  = s[COEFF_BITS] ? {1'b1, {(COEFF_BITS-1){1'b0}}}
			                       : {1'b0, {(COEFF_BITS-1){1'b1}}};
		end else begin
			r.clip = 1'b0;
			r.val  = s[COEFF_BITS-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hdl/svat_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svat_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module svat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> hdl/svat_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svat_ctrl: operation sequencer
// Accepts a transaction, steps the table scan and triggers the result.
// ----------------------------------------------------------------------------
module svat_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire svat_pkg::op_t       opcode,
	input  wire svat_pkg::ctrl_stat_t stat,
	output svat_pkg::ctrl_cmd_t      cmd,
	output logic                     busy
);
	import svat_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (opcode inside {OP_READ, OP_CLEAR}) ? S_FINISH : S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_end || stat.id_hit) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_SCAN: begin
				cmd.advance  = !stat.scan_end && !stat.id_hit;
				cmd.mark_hit = !stat.scan_end && stat.id_hit;
			end
			S_FINISH: cmd.emit = 1'b1;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> hdl/svat_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svat_dp: table datapath
// Holds the transaction, the entry memory, the scan index and the fill
// count, and forms the result in the finishing cycle.
// ----------------------------------------------------------------------------
module svat_dp #(
	parameter int CAPACITY = svat_pkg::DEF_CAPACITY
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire svat_pkg::in_item_t   command,
	input  wire svat_pkg::ctrl_cmd_t  cmd,
	output svat_pkg::ctrl_stat_t      stat,
	output svat_pkg::out_item_t       result,
	output logic                      result_valid
);
	import svat_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	in_item_t      item_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          hit_q;
	logic          done_q;
	out_item_t     res_d;
	out_item_t     res_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_entry;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	entry_t        rd_entry;
	sat_res_t      sum_re;
	sat_res_t      sum_im;
	logic          rd_ok;
	logic          full;

	svat_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_entry)
	);

	// The first read goes out with the accepting edge; each scan step
	// fetches the next entry so its data is ready in the next cycle.
	always_comb begin
		rd_en = cmd.load || cmd.advance;
		if (cmd.load) begin
			rd_addr = (command.opcode == OP_READ) ? AW'(command.read_index) : '0;
		end else begin
			rd_addr = AW'(k_q + CW'(1));
		end
	end

	assign stat.scan_end = (k_q >= count_q);
	assign stat.id_hit   = (rd_entry.id == item_q.state_id);

	assign sum_re = sat_add(rd_entry.re, item_q.coeff_re);
	assign sum_im = sat_add(rd_entry.im, item_q.coeff_im);
	assign rd_ok  = (32'(item_q.read_index) < 32'(count_q));
	assign full   = (count_q == CW'(CAPACITY));

	always_comb begin
		res_d    = '0;
		count_d  = count_q;
		wr_en    = 1'b0;
		wr_addr  = k_q[AW-1:0];
		wr_entry = rd_entry;
		case (item_q.opcode)
			OP_CLEAR: begin
				count_d      = '0;
				res_d.status = RS_MATCHED;
			end
			OP_READ: begin
				res_d.slot = SLOT_BITS'(item_q.read_index);
				if (rd_ok) begin
					res_d.status   = RS_READ_OK;
					res_d.entry_id = rd_entry.id;
					res_d.entry_re = rd_entry.re;
					res_d.entry_im = rd_entry.im;
				end else begin
					res_d.status = RS_READ_OOR;
				end
			end
			OP_ACCUM, OP_INSERT: begin
				if (hit_q) begin
					res_d.status   = RS_MATCHED;
					res_d.slot     = SLOT_BITS'(k_q);
					res_d.entry_id = rd_entry.id;
					res_d.entry_re = rd_entry.re;
					res_d.entry_im = rd_entry.im;
					if (item_q.opcode == OP_ACCUM) begin
						wr_en           = cmd.emit;
						wr_entry.re     = sum_re.val;
						wr_entry.im     = sum_im.val;
						res_d.entry_re  = sum_re.val;
						res_d.entry_im  = sum_im.val;
						res_d.saturated = sum_re.clip || sum_im.clip;
					end
				end else if (full) begin
					res_d.status = RS_FULL;
				end else begin
					wr_en          = cmd.emit;
					wr_addr        = count_q[AW-1:0];
					wr_entry.id    = item_q.state_id;
					wr_entry.re    = item_q.coeff_re;
					wr_entry.im    = item_q.coeff_im;
					count_d        = count_q + CW'(1);
					res_d.status   = RS_APPENDED;
					res_d.slot     = SLOT_BITS'(count_q);
					res_d.entry_id = item_q.state_id;
					res_d.entry_re = item_q.coeff_re;
					res_d.entry_im = item_q.coeff_im;
				end
			end
			default: ;
		endcase
		res_d.entry_count = COUNT_BITS'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			k_q     <= '0;
			hit_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.load) begin
				k_q   <= '0;
				hit_q <= 1'b0;
			end else if (cmd.advance) begin
				k_q <= k_q + CW'(1);
			end
			if (cmd.mark_hit) begin
				hit_q <= 1'b1;
			end
			if (cmd.emit) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= command;
		end
		if (cmd.emit) begin
			res_q <= res_d;
		end
	end

	assign result       = res_q;
	assign result_valid = done_q;

endmodule
`default_nettype wire

>>> hdl/sparse_vector_accumulate_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_vector_accumulate_table: lookup-or-insert store of complex entries
// Accumulates, inserts, reads and clears entries kept in arrival order.
// ----------------------------------------------------------------------------
//  channel   | signals                    | transfer
//  ----------+----------------------------+------------------------------
//  command   | start, busy, command       | start high while busy low
//  result    | result_valid, result       | one-cycle strobe, no stall
//
// Read and clear go from the accepting edge straight to the finishing state,
// whose closing edge loads the result; the strobe follows in the next cycle.
// Accumulate and insert walk the entry memory one entry per cycle through its
// single read port, up to the first match or the end of the stored entries.
// Reset empties the table at once; the entry memory itself is not cleared.
// A new transaction may be accepted in the cycle that shows the strobe.
// ----------------------------------------------------------------------------
module sparse_vector_accumulate_table #(
	parameter int CAPACITY = svat_pkg::DEF_CAPACITY
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire svat_pkg::in_item_t command,
	output logic                    result_valid,
	output svat_pkg::out_item_t     result
);
	import svat_pkg::*;

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	svat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (command.opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	svat_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.command      (command),
		.cmd          (cmd),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
`default_nettype wire

>>> hdl/svat_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svat_checker: port-level checks for the sparse vector accumulate table
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module svat_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire svat_pkg::in_item_t command,
	input wire logic               result_valid,
	input wire svat_pkg::out_item_t result
);
	import svat_pkg::*;

	// A clear transaction answers, after its finishing state, with an empty table.
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command.opcode == OP_CLEAR)
		|-> ##2 (result_valid && result.entry_count == '0))
		else $error("clear did not return an empty table in time");

	// A read transaction answers with a strobe after its finishing state.
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command.opcode == OP_READ) |-> ##2 result_valid)
		else $error("read result missing");

	// Reads, drops and out-of-range reads never report clipping.
	a_no_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.status == RS_READ_OK || result.status == RS_READ_OOR
			|| result.status == RS_FULL)) |-> !result.saturated)
		else $error("saturated set on a non-accumulating result");

	// Each result strobe lasts a single cycle.
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for more than one cycle");

endmodule

bind sparse_vector_accumulate_table svat_checker u_svat_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.command      (command),
	.result_valid (result_valid),
	.result       (result)
);
`default_nettype wire

>>> sim/sparse_vector_accumulate_table_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_vector_accumulate_table_tb: self-checking bench for the entry table
// A directed table covers the field extremes, saturation, insert of a present
// id, reads in and out of range and clear; a fill then makes a full store.
// Random traffic draws ids from pools of varying size so matches, appends and
// drops all occur; results are held to row values or a behavioral predictor.
// ----------------------------------------------------------------------------
module sparse_vector_accumulate_table_tb;

	import svat_pkg::*;

	localparam int  ITEM_TOTAL   = 1700;
	localparam int  CYCLE_LIMIT  = 1000000;
	localparam int  TAIL_CYCLES  = DEF_CAPACITY + 8;
	localparam int  POOL_SIZE    = 128;
	localparam int  ROW_MAX      = 32;
	localparam int  RESULT_DEPTH = 8;
	localparam longint COEFF_MAX = (longint'(1) <<< (COEFF_BITS - 1)) - 1;
	localparam longint COEFF_MIN = -COEFF_MAX - 1;

	typedef struct {
		in_item_t  cmd;
		bit        typed;
		out_item_t want;
	} directed_row_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  command;
	logic      result_valid;
	out_item_t result;

	// Predicted contents of the table.
	logic [ID_BITS-1:0]           stored_id [DEF_CAPACITY];
	logic signed [COEFF_BITS-1:0] stored_re [DEF_CAPACITY];
	logic signed [COEFF_BITS-1:0] stored_im [DEF_CAPACITY];
	int                           stored_count;

	// Expected results in order, kept in a small ring.
	out_item_t          expected_ring [RESULT_DEPTH];
	int                 ring_wr;
	int                 ring_rd;
	out_item_t          oldest_result;
	logic [ID_BITS-1:0] id_pool [POOL_SIZE];
	directed_row_t      directed_rows [ROW_MAX];
	int                 row_count;
	int                 mismatch_count;
	int                 items_sent;
	bit                 idle_off;

	sparse_vector_accumulate_table i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.result_valid (result_valid),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic signed [COEFF_BITS-1:0] clamp_add(
			input logic signed [COEFF_BITS-1:0] a,
			input logic signed [COEFF_BITS-1:0] b,
			inout bit clipped);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > COEFF_MAX) begin
			clipped = 1'b1;
			s = COEFF_MAX;
		end else if (s < COEFF_MIN) begin
			clipped = 1'b1;
			s = COEFF_MIN;
		end
		return s[COEFF_BITS-1:0];
	endfunction

	// Applies one transaction to the predicted table and returns its result.
	function automatic out_item_t predict_table_result(input in_item_t c);
		out_item_t r;
		int        hit;
		bit        clipped;
		r = '0;
		r.status = RS_MATCHED;
		hit = -1;
		clipped = 1'b0;
		case (c.opcode)
			OP_CLEAR: stored_count = 0;
			OP_READ: begin
				r.slot = c.read_index;
				if (int'(c.read_index) < stored_count) begin
					r.status   = RS_READ_OK;
					r.entry_id = stored_id[c.read_index];
					r.entry_re = stored_re[c.read_index];
					r.entry_im = stored_im[c.read_index];
				end else begin
					r.status = RS_READ_OOR;
				end
			end
			default: begin
				for (int k = 0; k < stored_count; k++)
					if (hit < 0 && stored_id[k] == c.state_id)
						hit = k;
				if (hit >= 0) begin
					if (c.opcode == OP_ACCUM) begin
						stored_re[hit] = clamp_add(stored_re[hit], c.coeff_re, clipped);
						stored_im[hit] = clamp_add(stored_im[hit], c.coeff_im, clipped);
					end
					r.status    = RS_MATCHED;
					r.slot      = hit[SLOT_BITS-1:0];
					r.entry_id  = stored_id[hit];
					r.entry_re  = stored_re[hit];
					r.entry_im  = stored_im[hit];
					r.saturated = clipped;
				end else if (stored_count >= DEF_CAPACITY) begin
					r.status = RS_FULL;
				end else begin
					stored_id[stored_count] = c.state_id;
					stored_re[stored_count] = c.coeff_re;
					stored_im[stored_count] = c.coeff_im;
					r.status   = RS_APPENDED;
					r.slot     = stored_count[SLOT_BITS-1:0];
					r.entry_id = c.state_id;
					r.entry_re = c.coeff_re;
					r.entry_im = c.coeff_im;
					stored_count++;
				end
			end
		endcase
		r.entry_count = stored_count[COUNT_BITS-1:0];
		return r;
	endfunction

	function automatic in_item_t mk_cmd(input op_t op, input logic [ID_BITS-1:0] id,
			input logic [COEFF_BITS-1:0] re, input logic [COEFF_BITS-1:0] im,
			input logic [IDX_BITS-1:0] idx);
		in_item_t c;
		c.opcode     = op;
		c.state_id   = id;
		c.coeff_re   = re;
		c.coeff_im   = im;
		c.read_index = idx;
		return c;
	endfunction

	function automatic out_item_t mk_res(input status_t st, input logic [SLOT_BITS-1:0] slot,
			input logic [ID_BITS-1:0] id, input logic [COEFF_BITS-1:0] re,
			input logic [COEFF_BITS-1:0] im, input logic sat,
			input logic [COUNT_BITS-1:0] cnt);
		out_item_t r;
		r.status      = st;
		r.slot        = slot;
		r.entry_id    = id;
		r.entry_re    = re;
		r.entry_im    = im;
		r.saturated   = sat;
		r.entry_count = cnt;
		return r;
	endfunction

	function automatic void add_row(input in_item_t c, input bit typed, input out_item_t want);
		directed_rows[row_count].cmd   = c;
		directed_rows[row_count].typed = typed;
		directed_rows[row_count].want  = want;
		row_count++;
	endfunction

	function automatic logic [ID_BITS-1:0] random_id();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Mostly small values, with full-range and near-limit values mixed in so
	// that accumulation saturates now and then.
	function automatic logic [COEFF_BITS-1:0] random_coeff();
		case ($urandom_range(0, 7))
			0:       return $urandom;
			1:       return COEFF_BITS'(COEFF_MAX - longint'($urandom_range(0, 15)));
			2:       return COEFF_BITS'(COEFF_MIN + longint'($urandom_range(0, 15)));
			default: return $urandom_range(0, 32'h3ffff) - 32'h20000;
		endcase
	endfunction

	function automatic in_item_t random_command(input int pool_n, input int clear_pct);
		in_item_t c;
		int       r;
		c = mk_cmd(OP_ACCUM, random_id(), random_coeff(), random_coeff(),
			IDX_BITS'($urandom));
		r = $urandom_range(0, 99);
		if (r < clear_pct) begin
			c.opcode = OP_CLEAR;
		end else if (r < 25) begin
			c.opcode = OP_READ;
			if (stored_count > 0 && $urandom_range(0, 3) != 0)
				c.read_index = IDX_BITS'($urandom_range(0, stored_count - 1));
		end else if (r < 45) begin
			c.opcode = OP_INSERT;
		end
		// A few ids come from outside the pool as noise.
		if (c.opcode inside {OP_ACCUM, OP_INSERT} && $urandom_range(0, 9) != 0)
			c.state_id = id_pool[$urandom_range(0, pool_n - 1)];
		return c;
	endfunction

	function automatic int pick_gap();
		int r;
		if (idle_off)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Drives one transaction from a falling edge, waits for it to be taken and
	// records what the table should return for it.
	task automatic issue(input in_item_t c, input bit typed, input out_item_t want);
		int        gap;
		out_item_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		command = c;
		start   = 1'b1;
		do
			@(posedge clk);
		while (busy);
		predicted = predict_table_result(c);
		expected_ring[ring_wr % RESULT_DEPTH] = typed ? want : predicted;
		ring_wr++;
		items_sent++;
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (ring_wr == ring_rd) begin
				$display("%0t: unexpected result: actual %p", $time, result);
				mismatch_count++;
			end else begin
				oldest_result = expected_ring[ring_rd % RESULT_DEPTH];
				ring_rd++;
				check_field("status", 64'(oldest_result.status), 64'(result.status));
				check_field("slot", 64'(oldest_result.slot), 64'(result.slot));
				check_field("entry_id", 64'(oldest_result.entry_id), 64'(result.entry_id));
				check_field("entry_re", 64'(oldest_result.entry_re), 64'(result.entry_re));
				check_field("entry_im", 64'(oldest_result.entry_im), 64'(result.entry_im));
				check_field("saturated", 64'(oldest_result.saturated),
					64'(result.saturated));
				check_field("entry_count", 64'(oldest_result.entry_count),
					64'(result.entry_count));
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int pool_n;
		int clear_pct;
		int phase_len;
		arst_n         = 1'b0;
		start          = 1'b0;
		command        = '0;
		stored_count   = 0;
		mismatch_count = 0;
		items_sent     = 0;
		row_count      = 0;
		ring_wr        = 0;
		ring_rd        = 0;
		idle_off       = 1'b0;
		foreach (id_pool[i])
			id_pool[i] = random_id();
		id_pool[0] = '0;
		id_pool[1] = '1;

		add_row(mk_cmd(OP_READ, '0, '0, '0, 6'd0), 1'b1,
			mk_res(RS_READ_OOR, 6'd0, '0, '0, '0, 1'b0, 7'd0));
		add_row(mk_cmd(OP_READ, '1, '1, '1, 6'd63), 1'b1,
			mk_res(RS_READ_OOR, 6'd63, '0, '0, '0, 1'b0, 7'd0));
		add_row(mk_cmd(OP_ACCUM, '0, 32'h7fffffff, 32'h80000000, 6'd63), 1'b1,
			mk_res(RS_APPENDED, 6'd0, '0, 32'h7fffffff, 32'h80000000, 1'b0, 7'd1));
		add_row(mk_cmd(OP_ACCUM, '0, 32'h00000001, 32'hffffffff, 6'd0), 1'b1,
			mk_res(RS_MATCHED, 6'd0, '0, 32'h7fffffff, 32'h80000000, 1'b1, 7'd1));
		add_row(mk_cmd(OP_ACCUM, '1, '0, '0, 6'd0), 1'b1,
			mk_res(RS_APPENDED, 6'd1, '1, '0, '0, 1'b0, 7'd2));
		// Insert of a present id leaves the entry alone.
		add_row(mk_cmd(OP_INSERT, '1, 32'd5, 32'd6, 6'd0), 1'b1,
			mk_res(RS_MATCHED, 6'd1, '1, '0, '0, 1'b0, 7'd2));
		add_row(mk_cmd(OP_INSERT, 48'h123456789abc, 32'hffffffff, 32'h00000001, 6'd0), 1'b1,
			mk_res(RS_APPENDED, 6'd2, 48'h123456789abc, 32'hffffffff, 32'h00000001,
				1'b0, 7'd3));
		add_row(mk_cmd(OP_ACCUM, '0, 32'h80000000, 32'h7fffffff, 6'd0), 1'b1,
			mk_res(RS_MATCHED, 6'd0, '0, 32'hffffffff, 32'hffffffff, 1'b0, 7'd3));
		add_row(mk_cmd(OP_ACCUM, '0, 32'h80000000, 32'h80000000, 6'd0), 1'b1,
			mk_res(RS_MATCHED, 6'd0, '0, 32'h80000000, 32'h80000000, 1'b1, 7'd3));
		add_row(mk_cmd(OP_ACCUM, 48'h123456789abc, 32'h00010000, 32'hffff8000, 6'd0),
			1'b0, '0);
		add_row(mk_cmd(OP_READ, '0, '0, '0, 6'd2), 1'b0, '0);
		add_row(mk_cmd(OP_READ, '0, '0, '0, 6'd3), 1'b1,
			mk_res(RS_READ_OOR, 6'd3, '0, '0, '0, 1'b0, 7'd3));
		add_row(mk_cmd(OP_INSERT, 48'h1, 32'h7fffffff, 32'h7fffffff, 6'd0), 1'b1,
			mk_res(RS_APPENDED, 6'd3, 48'h1, 32'h7fffffff, 32'h7fffffff, 1'b0, 7'd4));
		add_row(mk_cmd(OP_CLEAR, '1, '1, '1, 6'd63), 1'b1,
			mk_res(RS_MATCHED, 6'd0, '0, '0, '0, 1'b0, 7'd0));
		add_row(mk_cmd(OP_READ, '0, '0, '0, 6'd0), 1'b1,
			mk_res(RS_READ_OOR, 6'd0, '0, '0, '0, 1'b0, 7'd0));
		// After a clear the old entry at slot 0 must not match.
		add_row(mk_cmd(OP_ACCUM, '0, '0, '0, 6'd0), 1'b1,
			mk_res(RS_APPENDED, 6'd0, '0, '0, '0, 1'b0, 7'd1));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < row_count; i++)
			issue(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

		// Fill the table to capacity, then try to grow it and hit its last slot.
		issue(mk_cmd(OP_CLEAR, random_id(), $urandom, $urandom, IDX_BITS'($urandom)),
			1'b0, '0);
		for (int i = 0; i < DEF_CAPACITY; i++)
			issue(mk_cmd((i % 2) ? OP_INSERT : OP_ACCUM, id_pool[i], random_coeff(),
				random_coeff(), IDX_BITS'($urandom)), 1'b0, '0);
		issue(mk_cmd(OP_ACCUM, random_id(), random_coeff(), random_coeff(),
			IDX_BITS'($urandom)), 1'b0, '0);
		issue(mk_cmd(OP_INSERT, random_id(), random_coeff(), random_coeff(),
			IDX_BITS'($urandom)), 1'b0, '0);
		issue(mk_cmd(OP_ACCUM, id_pool[DEF_CAPACITY-1], random_coeff(), random_coeff(),
			IDX_BITS'($urandom)), 1'b0, '0);
		issue(mk_cmd(OP_READ, random_id(), $urandom, $urandom, 6'd63), 1'b0, '0);
		issue(mk_cmd(OP_READ, random_id(), $urandom, $urandom, 6'd0), 1'b0, '0);

		// Random phases: the pool size decides how often ids repeat, and phases
		// without clears let the table run full.
		while (items_sent < ITEM_TOTAL) begin
			case ($urandom_range(0, 4))
				0:       pool_n = 4;
				1:       pool_n = 16;
				2:       pool_n = 48;
				3:       pool_n = 96;
				default: pool_n = POOL_SIZE;
			endcase
			clear_pct = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
			idle_off  = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(60, 140);
			repeat (phase_len)
				if (items_sent < ITEM_TOTAL)
					issue(random_command(pool_n, clear_pct), 1'b0, '0);
		end
		start = 1'b0;

		while (ring_wr != ring_rd)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
